FILE: hw/rtl/hdc_pkg.sv
// Shared types, constants and curve helpers for the Hilbert depth-to-colour encoder.
package hdc_pkg;

  // Field and register widths.
  localparam int VAL_W      = 15;
  localparam int IDX_W      = 14;
  localparam int AXIS_W     = 7;
  localparam int FRAC_W     = 7;
  localparam int CFG_W      = 3;
  localparam int USED_W     = 5;
  localparam int COLOR_BITS = 8;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  // Curve levels: the first curve stage handles levels below the split, the second the rest.
  localparam int LEVELS      = 7;
  localparam int SPLIT_LEVEL = 4;

  // Reset values of the configuration registers.
  localparam logic [CFG_W-1:0] ALGO_BITS_RST    = 3'd4;
  localparam logic [CFG_W-1:0] SEGMENT_BITS_RST = 3'd4;

  // Configuration register indexes.
  typedef enum logic {
    CFG_ALGO_BITS    = 1'b0,
    CFG_SEGMENT_BITS = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [CFG_W-1:0] algo_bits;
    logic [CFG_W-1:0] segment_bits;
  } cfg_t;

  // Item after the split into fraction and curve indexes.
  typedef struct packed {
    logic [IDX_W-1:0]  idx_a;
    logic [IDX_W-1:0]  idx_b;
    logic [FRAC_W-1:0] frac;
    logic              last;
    logic              oor;
  } prep_t;

  // Item while the curve cells are being built level by level.
  typedef struct packed {
    logic [IDX_W-1:0]  idx_a;
    logic [IDX_W-1:0]  idx_b;
    logic [AXIS_W-1:0] xa;
    logic [AXIS_W-1:0] ya;
    logic [AXIS_W-1:0] xb;
    logic [AXIS_W-1:0] yb;
    logic [FRAC_W-1:0] frac;
    logic              last;
    logic              oor;
  } curve_t;

  typedef struct packed {
    logic [AXIS_W-1:0] x;
    logic [AXIS_W-1:0] y;
  } cell_t;

  // One level of the d2xy walk: rotate or reflect the sub-square, then place it.
  function automatic cell_t hdc_level(cell_t c, logic [1:0] q, logic [2:0] lvl);
    logic              rx;
    logic              ry;
    logic [AXIS_W-1:0] mask;
    logic [AXIS_W-1:0] bit_s;
    logic [AXIS_W-1:0] x;
    logic [AXIS_W-1:0] y;
    logic [AXIS_W-1:0] h;
    cell_t             r;
    rx    = q[1];
    ry    = q[0] ^ q[1];
    bit_s = AXIS_W'(1) << lvl;
    mask  = bit_s - AXIS_W'(1);
    x     = c.x;
    y     = c.y;
    if (!ry) begin
      if (rx) begin
        x = ~x & mask;
        y = ~y & mask;
      end
      h = x;
      x = y;
      y = h;
    end
    if (rx) x = x | bit_s;
    if (ry) y = y | bit_s;
    r.x = x;
    r.y = y;
    return r;
  endfunction

  // Move a scaled coordinate by the fraction towards the next cell.
  function automatic logic [COLOR_BITS-1:0] hdc_step(logic [AXIS_W-1:0] here,
                                                     logic [AXIS_W-1:0] there,
                                                     logic [FRAC_W-1:0] frac,
                                                     logic [CFG_W-1:0] seg);
    logic [COLOR_BITS-1:0] base;
    logic [COLOR_BITS-1:0] f;
    base = COLOR_BITS'(here) << seg;
    f    = COLOR_BITS'(frac);
    if (there > here) return base + f;
    else if (there < here) return base - f;
    else return base;
  endfunction

endpackage

FILE: hw/rtl/hilbert_depth_to_color_encoder_top.sv
// Top level of the Hilbert depth-to-colour encoder: configuration and four-stage pipeline.
//
//   Channel  Direction  Handshake              Contents
//   in_      slave      in_tvalid/in_tready    tdata: depth_value
//   out_     master     out_tvalid/out_tready  tdata: color_x, color_y; tuser: out_of_range
//   cfg_     slave      cfg_valid/cfg_ready    cfg_index, cfg_data
//
// An item passes four register stages: split, two groups of curve levels (four, then three)
// and the blend, in that order; the blend register drives the output. One item enters per
// cycle unless a stalled output has backed up the stages.
// A stage takes a new item whenever it is empty or its successor takes its item, so bubbles
// close up behind a stalled output. Reset empties every stage and restores both registers.
// Configuration writes are always accepted and take effect on the next cycle.
module hilbert_depth_to_color_encoder_top import hdc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [14:0] depth_value, [15] zero
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [7:0] color_x, [15:8] color_y
  output logic                   out_tuser,  // [0] out_of_range
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  cfg_t                  cfg_r;
  cfg_t                  cfg_nxt;
  logic                  p_valid;
  logic                  p_ready;
  prep_t                 p_data;
  curve_t                c0_in;
  logic                  c0_valid;
  logic                  c0_ready;
  curve_t                c0_data;
  logic                  c1_valid;
  logic                  c1_ready;
  curve_t                c1_data;
  logic [COLOR_BITS-1:0] col_x;
  logic [COLOR_BITS-1:0] col_y;

  // Configuration register writes.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_ALGO_BITS:    cfg_nxt.algo_bits    = cfg_data;
        CFG_SEGMENT_BITS: cfg_nxt.segment_bits = cfg_data;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.algo_bits    <= ALGO_BITS_RST;
      cfg_r.segment_bits <= SEGMENT_BITS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Split stage.
  hdc_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .up_value (in_tdata[VAL_W-1:0]),
    .dn_valid (p_valid),
    .dn_ready (p_ready),
    .dn_data  (p_data)
  );

  // Both cells start at the origin before the first curve level.
  always_comb begin
    c0_in.idx_a = p_data.idx_a;
    c0_in.idx_b = p_data.idx_b;
    c0_in.xa    = '0;
    c0_in.ya    = '0;
    c0_in.xb    = '0;
    c0_in.yb    = '0;
    c0_in.frac  = p_data.frac;
    c0_in.last  = p_data.last;
    c0_in.oor   = p_data.oor;
  end

  // Lower curve levels.
  hdc_curve #(
    .FIRST_LEVEL (0),
    .LEVEL_COUNT (SPLIT_LEVEL)
  ) u_curve_lo (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (p_valid),
    .up_ready (p_ready),
    .up_data  (c0_in),
    .dn_valid (c0_valid),
    .dn_ready (c0_ready),
    .dn_data  (c0_data)
  );

  // Upper curve levels.
  hdc_curve #(
    .FIRST_LEVEL (SPLIT_LEVEL),
    .LEVEL_COUNT (LEVELS - SPLIT_LEVEL)
  ) u_curve_hi (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (c0_valid),
    .up_ready (c0_ready),
    .up_data  (c0_data),
    .dn_valid (c1_valid),
    .dn_ready (c1_ready),
    .dn_data  (c1_data)
  );

  // Blend and output register.
  hdc_blend u_blend (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (c1_valid),
    .up_ready (c1_ready),
    .up_data  (c1_data),
    .dn_valid (out_tvalid),
    .dn_ready (out_tready),
    .dn_x     (col_x),
    .dn_y     (col_y),
    .dn_oor   (out_tuser)
  );

  assign out_tdata = {col_y, col_x};

endmodule

FILE: hw/rtl/hdc_prep.sv
// First pipeline stage: splits the depth value into fraction, curve indexes and range flag.
module hdc_prep import hdc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             up_valid,
  output logic             up_ready,
  input  logic [VAL_W-1:0] up_value,
  output logic             dn_valid,
  input  logic             dn_ready,
  output prep_t            dn_data
);

  logic              valid_r;
  logic              valid_nxt;
  prep_t             data_r;
  prep_t             data_nxt;
  logic [FRAC_W-1:0] frac_mask;
  logic [IDX_W-1:0]  idx_mask;
  logic [VAL_W-1:0]  shifted;
  logic [USED_W-1:0] used;
  logic [VAL_W-1:0]  keep_mask;

  // Masks follow the configured widths.
  always_comb begin
    frac_mask = (FRAC_W'(1) << cfg.segment_bits) - FRAC_W'(1);
    idx_mask  = (IDX_W'(1) << {cfg.algo_bits, 1'b0}) - IDX_W'(1);
    shifted   = up_value >> cfg.segment_bits;
    used      = USED_W'({cfg.algo_bits, 1'b0}) + USED_W'(cfg.segment_bits);
    if (used >= USED_W'(VAL_W)) keep_mask = '1;
    else keep_mask = (VAL_W'(1) << used) - VAL_W'(1);
  end

  // Next contents of the stage register.
  always_comb begin
    data_nxt.frac  = up_value[FRAC_W-1:0] & frac_mask;
    data_nxt.idx_a = shifted[IDX_W-1:0] & idx_mask;
    data_nxt.idx_b = data_nxt.idx_a + IDX_W'(1);
    data_nxt.last  = (data_nxt.idx_a == idx_mask);
    data_nxt.oor   = |(up_value & ~keep_mask);
  end

  assign up_ready  = !valid_r || dn_ready;
  assign valid_nxt = up_ready ? up_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

FILE: hw/rtl/hdc_curve.sv
// Curve stage: runs a fixed group of Hilbert levels for the current and the next index.
module hdc_curve import hdc_pkg::*; #(
  parameter int FIRST_LEVEL = 0,
  parameter int LEVEL_COUNT = SPLIT_LEVEL
) (
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic up_valid,
  output logic up_ready,
  input  curve_t up_data,
  output logic dn_valid,
  input  logic dn_ready,
  output curve_t dn_data
);

  logic   valid_r;
  logic   valid_nxt;
  curve_t data_r;
  curve_t data_nxt;

  // Walk the levels of this stage; levels at or above the curve order leave the cells alone.
  always_comb begin
    cell_t ca;
    cell_t cb;
    data_nxt = up_data;
    ca.x = up_data.xa;
    ca.y = up_data.ya;
    cb.x = up_data.xb;
    cb.y = up_data.yb;
    for (int i = 0; i < LEVEL_COUNT; i++) begin
      if (3'(FIRST_LEVEL + i) < cfg.algo_bits) begin
        ca = hdc_level(ca, up_data.idx_a[2*(FIRST_LEVEL+i) +: 2], 3'(FIRST_LEVEL + i));
        cb = hdc_level(cb, up_data.idx_b[2*(FIRST_LEVEL+i) +: 2], 3'(FIRST_LEVEL + i));
      end
    end
    data_nxt.xa = ca.x;
    data_nxt.ya = ca.y;
    data_nxt.xb = cb.x;
    data_nxt.yb = cb.y;
  end

  assign up_ready  = !valid_r || dn_ready;
  assign valid_nxt = up_ready ? up_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

FILE: hw/rtl/hdc_blend.sv
// Last stage: scales the cell and moves it by the fraction; its register drives the output.
module hdc_blend import hdc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfg_t                  cfg,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  curve_t                up_data,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output logic [COLOR_BITS-1:0] dn_x,
  output logic [COLOR_BITS-1:0] dn_y,
  output logic                  dn_oor
);

  logic                  valid_r;
  logic                  valid_nxt;
  logic [COLOR_BITS-1:0] x_r;
  logic [COLOR_BITS-1:0] x_nxt;
  logic [COLOR_BITS-1:0] y_r;
  logic [COLOR_BITS-1:0] y_nxt;
  logic                  oor_r;

  // The last index of the curve only moves x, and always upwards.
  always_comb begin
    if (up_data.last) begin
      x_nxt = (COLOR_BITS'(up_data.xa) << cfg.segment_bits) + COLOR_BITS'(up_data.frac);
      y_nxt = COLOR_BITS'(up_data.ya) << cfg.segment_bits;
    end else begin
      x_nxt = hdc_step(up_data.xa, up_data.xb, up_data.frac, cfg.segment_bits);
      y_nxt = hdc_step(up_data.ya, up_data.yb, up_data.frac, cfg.segment_bits);
    end
  end

  assign up_ready  = !valid_r || dn_ready;
  assign valid_nxt = up_ready ? up_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      oor_r <= up_data.oor;
    end
  end

  assign dn_valid = valid_r;
  assign dn_x     = x_r;
  assign dn_y     = y_r;
  assign dn_oor   = oor_r;

endmodule

FILE: dv/tb_hilbert_depth_to_color_encoder_top.sv
// Self-checking testbench for the Hilbert depth-to-colour encoder top level.
module tb_hilbert_depth_to_color_encoder_top;
  import hdc_pkg::*;

  // Register stages between the input and the output.
  localparam int PIPE_DEPTH  = 4;
  localparam int IDLE_PCT    = 17;
  localparam int LONG_STALL  = 60;
  localparam int DRAIN_LIMIT = 2000;
  localparam int MAX_REPORTS = 10;

  // Expected colour of one depth item.
  typedef struct packed {
    logic [7:0] x;
    logic [7:0] y;
    logic       oor;
  } colour_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;   // [14:0] depth_value, [15] zero
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;         // [7:0] color_x, [15:8] color_y
  logic                   out_tuser;         // [0] out_of_range
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  cfg_reg_t               cfg_index  = CFG_ALGO_BITS;
  logic [CFG_W-1:0]       cfg_data   = '0;

  // Shadow copy of the configuration registers.
  logic [CFG_W-1:0] algo_bits    = ALGO_BITS_RST;
  logic [CFG_W-1:0] segment_bits = SEGMENT_BITS_RST;

  colour_t expected_colours[$];
  int      mismatches      = 0;
  int      depths_sent     = 0;
  int      colours_checked = 0;
  int      settings_seen   = 1;
  int      oor_seen        = 0;
  bit      quiet           = 1'b0;
  logic    stall_req       = 1'b0;
  int      stall_left      = 0;

  hilbert_depth_to_color_encoder_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Clock with a period of ten units.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Generous overall limit on the run.
  initial begin
    #3000000;
    $display("tb_hilbert_depth_to_color_encoder_top failed");
    $finish;
  end

  // Walk the curve index down to its cell, two index bits per level.
  function automatic void curve_cell(input int unsigned idx, input int unsigned order,
                                     output int unsigned cx, output int unsigned cy);
    int unsigned x;
    int unsigned y;
    int unsigned t;
    int unsigned s;
    int unsigned rx;
    int unsigned ry;
    int unsigned h;
    x = 0;
    y = 0;
    t = idx;
    for (s = 1; s < (32'd1 << order); s = s << 1) begin
      rx = 1 & (t >> 1);
      ry = 1 & (t ^ rx);
      if (ry == 0) begin
        if (rx == 1) begin
          x = s - 1 - x;
          y = s - 1 - y;
        end
        h = x;
        x = y;
        y = h;
      end
      x = x + s * rx;
      y = y + s * ry;
      t = t >> 2;
    end
    cx = x;
    cy = y;
  endfunction

  // Scale a coordinate and nudge it by the fraction towards the next cell.
  function automatic logic [7:0] move_toward(input int unsigned here, input int unsigned there,
                                             input int unsigned frac, input int unsigned seg);
    int unsigned base;
    base = here << seg;
    if (there > here) base = base + frac;
    else if (there < here) base = base - frac;
    return 8'(base);
  endfunction

  // Colour that one depth value should produce under the given settings.
  function automatic colour_t predict_colour(input logic [14:0] depth, input logic [2:0] ab,
                                             input logic [2:0] sb);
    int unsigned used;
    int unsigned frac;
    int unsigned count;
    int unsigned idx;
    int unsigned x;
    int unsigned y;
    int unsigned nx;
    int unsigned ny;
    int unsigned value;
    colour_t     r;
    value = int'(depth);
    used  = 2 * int'(ab) + int'(sb);
    frac  = value & ((32'd1 << sb) - 1);
    count = 32'd1 << (2 * int'(ab));
    idx   = (value >> sb) & (count - 1);
    r.oor = (value >> used) != 0;
    curve_cell(idx, ab, x, y);
    if (idx + 1 != count) begin
      curve_cell(idx + 1, ab, nx, ny);
      r.x = move_toward(x, nx, frac, sb);
      r.y = move_toward(y, ny, frac, sb);
    end else begin
      // The last cell has no successor, so the fraction goes to x alone.
      r.x = 8'((x << sb) + frac);
      r.y = 8'(y << sb);
    end
    return r;
  endfunction

  function automatic void note_mismatch(input string msg);
    if (mismatches < MAX_REPORTS) $display("MISMATCH: %s", msg);
    mismatches++;
  endfunction

  // Receiver: random idling, quiet stretches and one long counted hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_req && stall_left == 0) begin
      out_tready <= 1'b0;
      stall_left <= LONG_STALL;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (quiet) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Compare each accepted colour item with the oldest expectation.
  always @(posedge clk) begin : check_colour
    colour_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_colours.size() == 0) begin
        note_mismatch($sformatf("unexpected item x=%0d y=%0d oor=%0b",
                                out_tdata[7:0], out_tdata[15:8], out_tuser));
      end else begin
        e = expected_colours.pop_front();
        if (out_tdata[7:0] !== e.x || out_tdata[15:8] !== e.y || out_tuser !== e.oor)
          note_mismatch($sformatf({"item %0d: expected x=%0d y=%0d oor=%0b, ",
                                   "got x=%0d y=%0d oor=%0b"},
                                  colours_checked, e.x, e.y, e.oor,
                                  out_tdata[7:0], out_tdata[15:8], out_tuser));
        colours_checked++;
      end
    end
  end

  // Offer one depth item, with an occasional one-cycle gap in front of it.
  task automatic send_depth(input logic [14:0] depth);
    colour_t e;
    if (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, depth};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    e = predict_colour(depth, algo_bits, segment_bits);
    if (e.oor) oor_seen++;
    expected_colours.push_back(e);
    depths_sent++;
  endtask

  // Stop offering and wait until every expected item has come out.
  task automatic wait_idle();
    int n;
    n = 0;
    in_tvalid <= 1'b0;
    while (expected_colours.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_ALGO_BITS) algo_bits = value;
    else segment_bits = value;
    @(posedge clk);
  endtask

  // Change both settings while the block is empty.
  task automatic apply_settings(input logic [CFG_W-1:0] ab, input logic [CFG_W-1:0] sb);
    wait_idle();
    write_reg(CFG_ALGO_BITS, ab);
    write_reg(CFG_SEGMENT_BITS, sb);
    settings_seen++;
  endtask

  // Random depth value, weighted towards in-range values and the end of the curve.
  function automatic logic [14:0] pick_depth(input logic [2:0] ab, input logic [2:0] sb);
    int unsigned used;
    int unsigned r;
    int unsigned last_idx;
    used     = 2 * int'(ab) + int'(sb);
    r        = $urandom_range(99);
    last_idx = (32'd1 << (2 * int'(ab))) - 1 - $urandom_range(1);
    if (r < 60) return 15'($urandom & ((64'd1 << used) - 1));
    if (r < 75) return 15'((last_idx << sb) | ($urandom & ((32'd1 << sb) - 1)));
    return 15'($urandom);
  endfunction

  // Reset settings: corners of the value, the last cell and high bits.
  task automatic test_reset_defaults();
    send_depth(15'h0000);
    send_depth(15'h0FFF);
    send_depth(15'h0FF0);
    send_depth(15'h0010);
    send_depth(15'h0008);
    send_depth(15'h7FFF);
    send_depth(15'h1000);
    wait_idle();
  endtask

  // Extreme settings, including zero-width fields and sums above eight.
  task automatic test_config_extremes();
    apply_settings(3'd0, 3'd5);
    send_depth(15'h001F);
    send_depth(15'h7FE5);
    apply_settings(3'd5, 3'd0);
    send_depth(15'h0000);
    send_depth(15'h03FF);
    send_depth(15'h0001);
    apply_settings(3'd7, 3'd7);
    send_depth(15'h7FFF);
    send_depth(15'h1234);
    send_depth(15'h0000);
    apply_settings(3'd7, 3'd1);
    send_depth(15'h7FFF);
    send_depth(15'h2AAA);
    apply_settings(3'd1, 3'd7);
    send_depth(15'h01FF);
    send_depth(15'h0200);
    apply_settings(3'd0, 3'd0);
    send_depth(15'h0000);
    send_depth(15'h0001);
    wait_idle();
  endtask

  // Hold the receiver off for a long stretch while items keep coming.
  task automatic test_backpressure();
    int i;
    apply_settings(3'd3, 3'd2);
    quiet     = 1'b1;
    stall_req <= 1'b1;
    @(posedge clk);
    stall_req <= 1'b0;
    for (i = 0; i < 40; i++) send_depth(pick_depth(algo_bits, segment_bits));
    wait_idle();
    quiet = 1'b0;
  endtask

  // Random phases, each under its own settings; one phase runs without idling.
  task automatic test_random_phases();
    int p;
    int i;
    for (p = 0; p < 13; p++) begin
      if (p == 0) apply_settings(3'd7, 3'd7);
      else if (p == 1) apply_settings(3'd1, 3'd1);
      else apply_settings(3'($urandom_range(7)), 3'($urandom_range(7)));
      quiet = (p == 6);
      for (i = 0; i < 130; i++) send_depth(pick_depth(algo_bits, segment_bits));
    end
    wait_idle();
    quiet = 1'b0;
  endtask

  // Test sequence.
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_config_extremes();
    test_backpressure();
    test_random_phases();
    wait_idle();
    if (expected_colours.size() != 0)
      note_mismatch($sformatf("%0d expected items never arrived", expected_colours.size()));
    $display("Sent %0d depth items under %0d register settings; %0d colour items checked.",
             depths_sent, settings_seen, colours_checked);
    $display("Out-of-range items: %0d; one long receiver hold-off; mismatches: %0d.",
             oor_seen, mismatches);
    if (mismatches == 0) $display("tb_hilbert_depth_to_color_encoder_top passed");
    else $display("tb_hilbert_depth_to_color_encoder_top failed");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/hdc_pkg.sv
hw/rtl/hdc_prep.sv
hw/rtl/hdc_curve.sv
hw/rtl/hdc_blend.sv
hw/rtl/hilbert_depth_to_color_encoder_top.sv
dv/tb_hilbert_depth_to_color_encoder_top.sv
